// ===== hw/rtl/sct_pkg.sv =====
// Package for the serial command tokenizer: types, character codes and state encodings.
// No dependencies; imported by serial_command_tokenizer and the testbench.
`timescale 1ns / 1ps

package sct_pkg;

    // Characters that the tokenizer reacts to.
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_NUL   = 8'h00;

    // Magnitude saturation point and the largest positive index.
    localparam logic [31:0] MAG_LIMIT = 32'h8000_0000;
    localparam logic [31:0] POS_MAX   = 32'h7FFF_FFFF;

    // Fixed field widths of the result transaction.
    localparam int DATA_COUNT_W = 6;

    // Register word addresses (byte address bit 3).
    localparam logic REG_COUNT = 1'b0;
    localparam logic REG_CHARS = 1'b1;

    // Where the tokenizer is within the current command.
    typedef enum logic [2:0] {
        PH_WAIT_HDR,
        PH_IN_HDR,
        PH_WAIT_DATA,
        PH_IN_DATA,
        PH_DONE
    } phase_t;

    // Index parser state of one command slot.
    typedef enum logic [1:0] {
        DM_START,
        DM_SIGN,
        DM_DIGITS,
        DM_END
    } digit_mode_t;

    // One entry of the slot memory.
    typedef struct packed {
        digit_mode_t mode;
        logic        negative;
        logic [31:0] value;
    } slot_entry_t;

    // Control sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HDR,
        ST_TERM_IDX,
        ST_EMIT_CMD,
        ST_DATA_RD,
        ST_DATA_LD
    } state_t;

endpackage

// ===== hw/rtl/serial_command_tokenizer.sv =====
// Top level of the serial command tokenizer: byte input channel, result output channel, APB port.
// Depends on sct_pkg; holds the slot memory and the data byte memory.
`timescale 1ns / 1ps

// The block takes one received byte per input transaction and splits ';'-terminated commands
// into a header token and a data token. Each of the MAX_CMDS command slots keeps its index
// parser state in a small slot memory with registered read data; a header byte walks that
// memory one slot per cycle in a read/modify/write pipeline and stalls the input until the
// walk ends, while a space, a zero byte or a data byte does not stall it. Data bytes go
// straight into a DATA_MAX-entry byte memory. On ';' the first seen slot below command_count
// selects the command: its entry is read, ST_TERM_IDX forms the saturated index, then one
// command result transaction and one transaction per stored data byte follow; each data byte
// takes a data memory read, then a load of the output register, which waits while the output
// is stalled. A ';' without a match does not stall the input. The output register lets a
// finished result wait while parsing of the next command goes on. Registers: command_count at
// byte address 0, command_chars at 8.
module serial_command_tokenizer #(
    parameter int MAX_CMDS = 8,
    parameter int DATA_MAX = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // Byte input channel.
    input  logic                             rx_valid,
    output logic                             rx_stall,
    input  logic [7:0]                       rx_byte,
    // Result output channel.
    output logic                             res_valid,
    input  logic                             res_stall,
    output logic                             is_data,
    output logic [7:0]                       cmd_char,
    output logic signed [31:0]               cmd_index,
    output logic [7:0]                       data_byte,
    output logic [sct_pkg::DATA_COUNT_W-1:0] data_count,
    output logic                             data_truncated,
    output logic                             last,
    // Configuration port.
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [3:0]                       paddr,
    input  logic [63:0]                      pwdata,
    output logic [63:0]                      prdata,
    output logic                             pready
);
    import sct_pkg::*;

    localparam int SLOT_W = (MAX_CMDS > 1) ? $clog2(MAX_CMDS) : 1;
    localparam int CNT_W  = $clog2(MAX_CMDS + 1);
    localparam int DW     = (DATA_MAX > 1) ? $clog2(DATA_MAX) : 1;
    localparam int LEN_W  = $clog2(DATA_MAX + 1);

    // Configuration registers.
    logic [3:0]  command_count_reg;
    logic [63:0] command_chars_reg;

    // Parsing state.
    state_t                state_reg, state_next;
    phase_t                phase_reg;
    logic [MAX_CMDS-1:0]   seen_reg;
    logic [MAX_CMDS-1:0]   slot_valid_reg;
    logic [7:0]            byte_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  p_valid_reg;
    logic [SLOT_W-1:0]     p_idx_reg;
    logic [SLOT_W-1:0]     chosen_reg;
    logic [LEN_W-1:0]      len_reg;
    logic                  ovf_reg;
    logic [LEN_W-1:0]      k_reg;

    // Memories and their registered read data.
    slot_entry_t           slot_mem [MAX_CMDS];
    slot_entry_t           slot_rd_reg;
    logic                  slot_rd_valid_reg;
    logic [7:0]            data_mem [DATA_MAX];
    logic [7:0]            data_rd_reg;

    // Held command result fields.
    logic [7:0]            hold_char_reg;
    logic [31:0]           hold_index_reg;

    // Output register.
    logic                  out_valid_reg;
    logic                  is_data_reg;
    logic [7:0]            cmd_char_reg;
    logic [31:0]           cmd_index_reg;
    logic [7:0]            data_byte_reg;
    logic [DATA_COUNT_W-1:0] data_count_reg;
    logic                  data_trunc_reg;
    logic                  last_reg;

    // Combinational control.
    logic                  rx_take;
    logic                  is_nul, is_semi, is_space;
    logic                  hdr_byte;
    logic                  data_in;
    logic                  found;
    logic [SLOT_W-1:0]     found_idx;
    logic                  slot_rd_en;
    logic [SLOT_W-1:0]     slot_rd_addr;
    logic                  out_free;
    logic                  load_cmd;
    logic                  load_data;
    logic                  do_clear;
    logic                  data_last;
    slot_entry_t           slot_cur;
    slot_entry_t           slot_new;
    logic [7:0]            slot_char;
    logic [31:0]           index_calc;
    phase_t                phase_next;
    logic                  cfg_write;

    // ---------------------------------------------------------------------------------
    // Configuration port. Registers are decoded on byte address bit 3.
    // ---------------------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = (paddr[3] == REG_CHARS) ? command_chars_reg
                                               : {60'd0, command_count_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            command_count_reg <= 4'd0;
            command_chars_reg <= 64'd0;
        end
        else if (cfg_write)
        begin
            if (paddr[3] == REG_COUNT)
            begin
                command_count_reg <= pwdata[3:0];
            end
            else
            begin
                command_chars_reg <= pwdata;
            end
        end
    end

    // ---------------------------------------------------------------------------------
    // Input decode. The input is only taken while the sequencer is idle.
    // ---------------------------------------------------------------------------------
    assign rx_stall = (state_reg != ST_IDLE);
    assign rx_take  = rx_valid && !rx_stall;
    assign is_nul   = (rx_byte == CH_NUL);
    assign is_semi  = (rx_byte == CH_SEMI);
    assign is_space = (rx_byte == CH_SPACE);

    // Phase tracking for ordinary bytes; the header and data flags say what work follows.
    always_comb
    begin
        phase_next = phase_reg;
        hdr_byte   = 1'b0;
        data_in    = 1'b0;
        unique case (phase_reg)
            PH_WAIT_HDR:
            begin
                if (!is_space)
                begin
                    phase_next = PH_IN_HDR;
                    hdr_byte   = 1'b1;
                end
            end
            PH_IN_HDR:
            begin
                if (is_space)
                begin
                    phase_next = PH_WAIT_DATA;
                end
                else
                begin
                    hdr_byte = 1'b1;
                end
            end
            PH_WAIT_DATA:
            begin
                if (!is_space)
                begin
                    phase_next = PH_IN_DATA;
                    data_in    = 1'b1;
                end
            end
            PH_IN_DATA:
            begin
                if (is_space)
                begin
                    phase_next = PH_DONE;
                end
                else
                begin
                    data_in = 1'b1;
                end
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase
    end

    // The first seen slot below the configured count selects the command.
    always_comb
    begin
        found     = 1'b0;
        found_idx = '0;
        for (int i = MAX_CMDS - 1; i >= 0; i--)
        begin
            if (seen_reg[i] && (4'(i) < command_count_reg))
            begin
                found     = 1'b1;
                found_idx = SLOT_W'(i);
            end
        end
    end

    // ---------------------------------------------------------------------------------
    // Slot update: the modify step of the header read/modify/write pipeline.
    // ---------------------------------------------------------------------------------
    assign slot_cur  = slot_rd_valid_reg ? slot_rd_reg : '0;
    assign slot_char = command_chars_reg[{p_idx_reg, 3'b000} +: 8];

    always_comb
    begin
        logic        digit;
        logic [3:0]  d;
        logic [35:0] m;
        digit    = (byte_reg >= CH_ZERO) && (byte_reg <= CH_NINE);
        d        = digit ? 4'(byte_reg - CH_ZERO) : 4'd0;
        m        = {1'b0, slot_cur.value, 3'b000} + {3'b000, slot_cur.value, 1'b0}
                   + {32'd0, d};
        slot_new = slot_cur;
        if (seen_reg[p_idx_reg])
        begin
            case (slot_cur.mode)
                DM_START:
                begin
                    if (byte_reg == CH_PLUS)
                    begin
                        slot_new.mode = DM_SIGN;
                    end
                    else if (byte_reg == CH_MINUS)
                    begin
                        slot_new.mode     = DM_SIGN;
                        slot_new.negative = 1'b1;
                    end
                    else if (digit)
                    begin
                        slot_new.mode  = DM_DIGITS;
                        slot_new.value = {28'd0, d};
                    end
                    else
                    begin
                        slot_new.mode = DM_END;
                    end
                end
                DM_SIGN, DM_DIGITS:
                begin
                    if (digit)
                    begin
                        slot_new.mode  = DM_DIGITS;
                        slot_new.value = (m > {4'd0, MAG_LIMIT}) ? MAG_LIMIT : m[31:0];
                    end
                    else
                    begin
                        slot_new.mode = DM_END;
                    end
                end
                default:
                begin
                    slot_new = slot_cur;
                end
            endcase
        end
        else if (byte_reg == slot_char)
        begin
            slot_new = '0;
        end
    end

    // Index of the chosen slot: negation of the magnitude, or positive saturation.
    always_comb
    begin
        if (slot_cur.negative)
        begin
            index_calc = 32'd0 - slot_cur.value;
        end
        else
        begin
            index_calc = (slot_cur.value > POS_MAX) ? POS_MAX : slot_cur.value;
        end
    end

    // ---------------------------------------------------------------------------------
    // Sequencer: next state.
    // ---------------------------------------------------------------------------------
    assign out_free  = !out_valid_reg || !res_stall;
    assign data_last = ((k_reg + LEN_W'(1)) == len_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (rx_take && !is_nul)
                begin
                    if (is_semi)
                    begin
                        if (found)
                        begin
                            state_next = ST_TERM_IDX;
                        end
                    end
                    else if (hdr_byte)
                    begin
                        state_next = ST_HDR;
                    end
                end
            end
            ST_HDR:
            begin
                if (cnt_reg == CNT_W'(MAX_CMDS))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_TERM_IDX:
            begin
                state_next = ST_EMIT_CMD;
            end
            ST_EMIT_CMD:
            begin
                if (out_free)
                begin
                    state_next = (len_reg == '0) ? ST_IDLE : ST_DATA_RD;
                end
            end
            ST_DATA_RD:
            begin
                state_next = ST_DATA_LD;
            end
            ST_DATA_LD:
            begin
                if (out_free)
                begin
                    state_next = data_last ? ST_IDLE : ST_DATA_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer: strobes.
    always_comb
    begin
        slot_rd_en   = 1'b0;
        slot_rd_addr = '0;
        load_cmd     = 1'b0;
        load_data    = 1'b0;
        do_clear     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (rx_take && is_semi)
                begin
                    slot_rd_en   = found;
                    slot_rd_addr = found_idx;
                    do_clear     = !found;
                end
            end
            ST_HDR:
            begin
                slot_rd_en   = (cnt_reg < CNT_W'(MAX_CMDS));
                slot_rd_addr = cnt_reg[SLOT_W-1:0];
            end
            ST_EMIT_CMD:
            begin
                load_cmd = out_free;
                do_clear = out_free && (len_reg == '0);
            end
            ST_DATA_LD:
            begin
                load_data = out_free;
                do_clear  = out_free && data_last;
            end
            default:
            begin
                slot_rd_en = 1'b0;
            end
        endcase
    end

    // ---------------------------------------------------------------------------------
    // Control registers.
    // ---------------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            phase_reg      <= PH_WAIT_HDR;
            seen_reg       <= '0;
            slot_valid_reg <= '0;
            cnt_reg        <= '0;
            p_valid_reg    <= 1'b0;
            len_reg        <= '0;
            ovf_reg        <= 1'b0;
            k_reg          <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            p_valid_reg <= (state_reg == ST_HDR) && slot_rd_en;

            if (state_reg == ST_HDR)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            else
            begin
                cnt_reg <= '0;
            end

            // Write stage of the header pipeline marks the slot as written, and as seen on a match.
            if (p_valid_reg)
            begin
                slot_valid_reg[p_idx_reg] <= 1'b1;
                if (!seen_reg[p_idx_reg] && (byte_reg == slot_char))
                begin
                    seen_reg[p_idx_reg] <= 1'b1;
                end
            end

            if (rx_take && !is_nul && !is_semi)
            begin
                phase_reg <= phase_next;
                if (data_in)
                begin
                    if (len_reg < LEN_W'(DATA_MAX))
                    begin
                        len_reg <= len_reg + LEN_W'(1);
                    end
                    else
                    begin
                        ovf_reg <= 1'b1;
                    end
                end
            end

            if (state_reg == ST_EMIT_CMD)
            begin
                k_reg <= '0;
            end
            else if (load_data)
            begin
                k_reg <= k_reg + LEN_W'(1);
            end

            if (load_cmd || load_data)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            // End of a command, with or without a match.
            if (do_clear)
            begin
                phase_reg      <= PH_WAIT_HDR;
                seen_reg       <= '0;
                slot_valid_reg <= '0;
                len_reg        <= '0;
                ovf_reg        <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------------------------
    // Payload registers.
    // ---------------------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (rx_take)
        begin
            byte_reg <= rx_byte;
        end
        if (rx_take && is_semi)
        begin
            chosen_reg <= found_idx;
        end
        p_idx_reg <= cnt_reg[SLOT_W-1:0];

        if (state_reg == ST_TERM_IDX)
        begin
            hold_char_reg  <= command_chars_reg[{chosen_reg, 3'b000} +: 8];
            hold_index_reg <= index_calc;
        end

        if (load_cmd)
        begin
            is_data_reg    <= 1'b0;
            cmd_char_reg   <= hold_char_reg;
            cmd_index_reg  <= hold_index_reg;
            data_byte_reg  <= 8'd0;
            data_count_reg <= DATA_COUNT_W'(len_reg);
            data_trunc_reg <= ovf_reg;
            last_reg       <= (len_reg == '0);
        end
        else if (load_data)
        begin
            is_data_reg   <= 1'b1;
            data_byte_reg <= data_rd_reg;
            last_reg      <= data_last;
        end
    end

    // ---------------------------------------------------------------------------------
    // Slot memory: one read port, one write port, registered read data.
    // ---------------------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (slot_rd_en)
        begin
            slot_rd_reg       <= slot_mem[slot_rd_addr];
            slot_rd_valid_reg <= slot_valid_reg[slot_rd_addr];
        end
        if (p_valid_reg)
        begin
            slot_mem[p_idx_reg] <= slot_new;
        end
    end

    // ---------------------------------------------------------------------------------
    // Data byte memory.
    // ---------------------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (rx_take && !is_nul && !is_semi && data_in && (len_reg < LEN_W'(DATA_MAX)))
        begin
            data_mem[len_reg[DW-1:0]] <= rx_byte;
        end
        if (state_reg == ST_DATA_RD)
        begin
            data_rd_reg <= data_mem[k_reg[DW-1:0]];
        end
    end

    // ---------------------------------------------------------------------------------
    // Outputs.
    // ---------------------------------------------------------------------------------
    assign res_valid      = out_valid_reg;
    assign is_data        = is_data_reg;
    assign cmd_char       = cmd_char_reg;
    assign cmd_index      = cmd_index_reg;
    assign data_byte      = data_byte_reg;
    assign data_count     = data_count_reg;
    assign data_truncated = data_trunc_reg;
    assign last           = last_reg;

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for serial_command_tokenizer: byte stream in, command results out.
// Depends on sct_pkg and the serial_command_tokenizer RTL; needs no files or arguments.
`timescale 1ns / 1ps

module testbench;

    import sct_pkg::*;

    localparam int MAX_CMDS = 8;
    localparam int DATA_MAX = 32;

    // Cycles a header byte may keep the block busy after its acceptance, with margin.
    localparam int DRAIN_CYCLES = 3 * (MAX_CMDS + 2);
    // Cycles without any accepted transaction before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 2000;
    // Length of the long receiver hold-off that fills the block up.
    localparam int HOLD_CYCLES = 300;
    // Least number of non-zero bytes sent per random phase.
    localparam int PHASE_ITEMS = 40;
    // Mismatch lines printed before the report goes quiet (it keeps counting).
    localparam int REPORT_CAP = 100;

    localparam logic [3:0] ADDR_COUNT = {REG_COUNT, 3'b000};
    localparam logic [3:0] ADDR_CHARS = {REG_CHARS, 3'b000};

    // Kinds of rows in the directed stimulus table.
    typedef enum logic [1:0] {
        ROW_TEXT,
        ROW_BYTE,
        ROW_COUNT,
        ROW_CHARS
    } row_op_t;

    // One result transaction as the block presents it.
    typedef struct {
        logic                    is_data;
        logic [7:0]              ch;
        logic signed [31:0]      idx;
        logic [7:0]              db;
        logic [DATA_COUNT_W-1:0] cnt;
        logic                    trunc;
        logic                    last;
    } cmd_result_t;

    // One directed row. Rows marked typed carry their expected outcome at the ';' that
    // ends their text: either nothing, or a single command result with no data.
    typedef struct {
        row_op_t            op;
        string              text;
        logic [63:0]        val;
        bit                 typed;
        bit                 hits;
        logic [7:0]         ch;
        logic signed [31:0] idx;
    } stim_row_t;

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    rx_valid;
    logic                    rx_stall;
    logic [7:0]              rx_byte;
    logic                    res_valid;
    logic                    res_stall;
    logic                    is_data;
    logic [7:0]              cmd_char;
    logic signed [31:0]      cmd_index;
    logic [7:0]              data_byte;
    logic [DATA_COUNT_W-1:0] data_count;
    logic                    data_truncated;
    logic                    last;
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [3:0]              paddr;
    logic [63:0]             pwdata;
    logic [63:0]             prdata;
    logic                    pready;

    serial_command_tokenizer #(
        .MAX_CMDS(MAX_CMDS),
        .DATA_MAX(DATA_MAX)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .rx_valid(rx_valid),
        .rx_stall(rx_stall),
        .rx_byte(rx_byte),
        .res_valid(res_valid),
        .res_stall(res_stall),
        .is_data(is_data),
        .cmd_char(cmd_char),
        .cmd_index(cmd_index),
        .data_byte(data_byte),
        .data_count(data_count),
        .data_truncated(data_truncated),
        .last(last),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------------------
    // Tokenizer predictor. It mirrors the two configuration registers and keeps its own
    // copy of the per-command parse state: one index parser per command slot, the data
    // token buffer and its overflow flag.
    // ------------------------------------------------------------------------------------
    logic [3:0]  reg_count;
    logic [63:0] reg_chars;

    phase_t      tok_phase;
    bit          slot_hit [MAX_CMDS];
    digit_mode_t slot_mode [MAX_CMDS];
    bit          slot_neg [MAX_CMDS];
    logic [31:0] slot_mag [MAX_CMDS];
    logic [7:0]  data_buf [DATA_MAX];
    int          data_len;
    bit          data_over;

    // Results caused by the byte just handed to the predictor, and all results still owed.
    cmd_result_t fresh_results[$];
    cmd_result_t cmd_results_due[$];

    function automatic void clear_command();
        tok_phase = PH_WAIT_HDR;
        for (int i = 0; i < MAX_CMDS; i++)
        begin
            slot_hit[i]  = 1'b0;
            slot_mode[i] = DM_START;
            slot_neg[i]  = 1'b0;
            slot_mag[i]  = '0;
        end
        data_len  = 0;
        data_over = 1'b0;
    endfunction

    // Advances the index parser of one slot that has already seen its character.
    function automatic void index_char(input int s, input logic [7:0] b);
        bit                dig;
        logic [31:0]       d;
        longint unsigned   m;
        dig = (b >= CH_ZERO) && (b <= CH_NINE);
        d   = dig ? 32'(b - CH_ZERO) : 32'd0;
        case (slot_mode[s])
            DM_START:
            begin
                if (b == CH_PLUS)
                    slot_mode[s] = DM_SIGN;
                else if (b == CH_MINUS)
                begin
                    slot_neg[s]  = 1'b1;
                    slot_mode[s] = DM_SIGN;
                end
                else if (dig)
                begin
                    slot_mag[s]  = d;
                    slot_mode[s] = DM_DIGITS;
                end
                else
                    slot_mode[s] = DM_END;
            end
            DM_SIGN, DM_DIGITS:
            begin
                if (dig)
                begin
                    // The magnitude sticks at 2^31 so that both signed extremes are reachable.
                    m = 64'(slot_mag[s]) * 10 + 64'(d);
                    if (m > 64'(MAG_LIMIT))
                        m = 64'(MAG_LIMIT);
                    slot_mag[s]  = m[31:0];
                    slot_mode[s] = DM_DIGITS;
                end
                else
                    slot_mode[s] = DM_END;
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic void header_char(input logic [7:0] b);
        for (int i = 0; i < MAX_CMDS; i++)
        begin
            if (slot_hit[i])
                index_char(i, b);
            else if (b == reg_chars[8*i +: 8])
            begin
                slot_hit[i]  = 1'b1;
                slot_mode[i] = DM_START;
                slot_neg[i]  = 1'b0;
                slot_mag[i]  = '0;
            end
        end
    endfunction

    function automatic void store_data(input logic [7:0] b);
        if (data_len < DATA_MAX)
        begin
            data_buf[data_len] = b;
            data_len++;
        end
        else
            data_over = 1'b1;
    endfunction

    // The ';' step: the first seen slot below the clamped count wins.
    function automatic void finish_command();
        int           n;
        int           pick;
        logic [31:0]  mag;
        cmd_result_t  r;
        n    = (reg_count > MAX_CMDS) ? MAX_CMDS : int'(reg_count);
        pick = -1;
        for (int i = 0; i < n; i++)
        begin
            if (slot_hit[i] && pick < 0)
                pick = i;
        end
        if (pick >= 0)
        begin
            mag = slot_mag[pick];
            r.ch = reg_chars[8*pick +: 8];
            if (slot_neg[pick])
                r.idx = -$signed(mag);
            else
                r.idx = (mag > POS_MAX) ? POS_MAX : mag;
            r.cnt   = DATA_COUNT_W'(data_len);
            r.trunc = data_over;
            for (int k = 0; k <= data_len; k++)
            begin
                r.is_data = (k > 0);
                r.db      = (k > 0) ? data_buf[k-1] : 8'd0;
                r.last    = (k == data_len);
                fresh_results.push_back(r);
            end
        end
        clear_command();
    endfunction

    // Works out the results that one accepted byte causes, into fresh_results.
    function automatic void tokenize_byte(input logic [7:0] b);
        fresh_results.delete();
        if (b == CH_NUL)
            return;
        if (b == CH_SEMI)
        begin
            finish_command();
            return;
        end
        case (tok_phase)
            PH_WAIT_HDR:
            begin
                if (b != CH_SPACE)
                begin
                    tok_phase = PH_IN_HDR;
                    header_char(b);
                end
            end
            PH_IN_HDR:
            begin
                if (b == CH_SPACE)
                    tok_phase = PH_WAIT_DATA;
                else
                    header_char(b);
            end
            PH_WAIT_DATA:
            begin
                if (b != CH_SPACE)
                begin
                    tok_phase = PH_IN_DATA;
                    store_data(b);
                end
            end
            PH_IN_DATA:
            begin
                if (b == CH_SPACE)
                    tok_phase = PH_DONE;
                else
                    store_data(b);
            end
            default:
            begin
            end
        endcase
    endfunction

    // ------------------------------------------------------------------------------------
    // Checking. Every accepted result transaction is compared with the oldest owed result.
    // ------------------------------------------------------------------------------------
    int errors = 0;

    task automatic report_mismatch(input string what, input longint want, input longint got);
        errors++;
        if (errors <= REPORT_CAP)
            $display("%0t: mismatch in %s: expected %0d, got %0d", $time, what, want, got);
    endtask

    always @(posedge clk)
    begin
        cmd_result_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            if (cmd_results_due.size() == 0)
                report_mismatch("result with none owed", 0, 1);
            else
            begin
                want = cmd_results_due.pop_front();
                if (is_data !== want.is_data)
                    report_mismatch("is_data", want.is_data, is_data);
                if (cmd_char !== want.ch)
                    report_mismatch("cmd_char", want.ch, cmd_char);
                if (cmd_index !== want.idx)
                    report_mismatch("cmd_index", want.idx, cmd_index);
                if (data_byte !== want.db)
                    report_mismatch("data_byte", want.db, data_byte);
                if (data_count !== want.cnt)
                    report_mismatch("data_count", want.cnt, data_count);
                if (data_truncated !== want.trunc)
                    report_mismatch("data_truncated", want.trunc, data_truncated);
                if (last !== want.last)
                    report_mismatch("last", want.last, last);
            end
        end
    end

    // The watchdog counts cycles in which neither channel moves a transaction. The longest
    // legal quiet stretch is the receiver hold-off, so the limit is several times that.
    int quiet_cycles = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((rx_valid && !rx_stall) || (res_valid && !res_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("testbench: errors");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------------------
    // Receiver. It stalls at random with the current percentage, and once runs a long
    // hold-off counted here, so that the output register and then the input back up.
    // ------------------------------------------------------------------------------------
    int src_idle_pct  = 0;
    int sink_idle_pct = 0;
    bit pressure_pending = 1'b0;

    initial
    begin
        res_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (pressure_pending)
            begin
                pressure_pending = 1'b0;
                res_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1)
                begin
                    @(negedge clk);
                    res_stall <= 1'b1;
                end
            end
            else
                res_stall <= ($urandom_range(99) < sink_idle_pct);
        end
    end

    // ------------------------------------------------------------------------------------
    // Sender side and configuration port.
    // ------------------------------------------------------------------------------------

    // Offers one byte, with random idle cycles ahead of it, and returns once it is accepted.
    // Valid stays high afterwards so that back-to-back transactions need no gap.
    task automatic put_byte(input logic [7:0] b);
        bit done;
        done = 1'b0;
        while (!done)
        begin
            @(negedge clk);
            if ($urandom_range(99) < src_idle_pct)
                rx_valid <= 1'b0;
            else
            begin
                rx_valid <= 1'b1;
                rx_byte  <= b;
                @(posedge clk);
                while (rx_stall)
                    @(posedge clk);
                done = 1'b1;
            end
        end
        tokenize_byte(b);
    endtask

    // Drops valid, waits for every owed result, then lets a header walk finish.
    task automatic wait_idle();
        @(negedge clk);
        rx_valid <= 1'b0;
        while (cmd_results_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    // Setup cycle, then access cycle; the register takes the value at the access edge.
    task automatic cfg_write(input logic [3:0] addr, input logic [63:0] value);
        wait_idle();
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (addr == ADDR_COUNT)
            reg_count = value[3:0];
        else
            reg_chars = value;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // ------------------------------------------------------------------------------------
    // Random stimulus.
    // ------------------------------------------------------------------------------------
    int phase_items;

    function automatic logic [7:0] token_byte();
        logic [7:0] b;
        b = 8'($urandom_range(1, 255));
        while (b == CH_SPACE || b == CH_SEMI)
            b = 8'($urandom_range(1, 255));
        return b;
    endfunction

    task automatic send_predicted(input logic [7:0] b);
        put_byte(b);
        foreach (fresh_results[i])
            cmd_results_due.push_back(fresh_results[i]);
        if (b != CH_NUL)
            phase_items++;
    endtask

    // Mostly well-formed commands with random content: leading spaces, a header built from
    // configured characters, signs, digit runs and random bytes, a data token, sometimes extra tokens and
    // a stray zero byte. The rest is raw noise that may or may not end in ';'.
    task automatic send_command(input bit long_data);
        logic [7:0] cmd[$];
        int         hdr_len;
        int         dat_len;
        int         sel;
        if (!long_data && $urandom_range(99) < 15)
        begin
            repeat ($urandom_range(1, 8))
                cmd.push_back(8'($urandom_range(0, 255)));
            if ($urandom_range(1) == 1)
                cmd.push_back(CH_SEMI);
        end
        else
        begin
            repeat ($urandom_range(0, 2))
                cmd.push_back(CH_SPACE);
            hdr_len = $urandom_range(1, 5);
            repeat (hdr_len)
            begin
                sel = $urandom_range(9);
                if (sel < 5)
                    cmd.push_back(reg_chars[8*$urandom_range(7) +: 8]);
                else if (sel == 5)
                    cmd.push_back(CH_ZERO + 8'($urandom_range(9)));
                else if (sel == 6)
                begin
                    // Long digit runs push the index into saturation.
                    repeat ($urandom_range(1, 11))
                        cmd.push_back(CH_ZERO + 8'($urandom_range(9)));
                end
                else if (sel == 7)
                    cmd.push_back(($urandom_range(1) == 1) ? CH_PLUS : CH_MINUS);
                else
                    cmd.push_back(token_byte());
            end
            repeat ($urandom_range(1, 2))
                cmd.push_back(CH_SPACE);
            sel = $urandom_range(99);
            if (long_data)
                dat_len = $urandom_range(20, DATA_MAX);
            else if (sel < 80)
                dat_len = $urandom_range(0, 6);
            else if (sel < 95)
                dat_len = $urandom_range(7, DATA_MAX - 1);
            else
                dat_len = $urandom_range(DATA_MAX, DATA_MAX + 8);
            repeat (dat_len)
                cmd.push_back(token_byte());
            if ($urandom_range(3) == 0)
            begin
                cmd.push_back(CH_SPACE);
                repeat ($urandom_range(1, 4))
                    cmd.push_back(token_byte());
            end
            if ($urandom_range(9) == 0)
                cmd.insert($urandom_range(cmd.size()), CH_NUL);
            cmd.push_back(CH_SEMI);
        end
        foreach (cmd[i])
            send_predicted(cmd[i]);
    endtask

    task automatic run_phase(input int src_pct, input int sink_pct, input logic [3:0] count,
                             input logic [63:0] chars);
        cfg_write(ADDR_COUNT, 64'(count));
        cfg_write(ADDR_CHARS, chars);
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        phase_items   = 0;
        while (phase_items < PHASE_ITEMS)
            send_command(1'b0);
    endtask

    // ------------------------------------------------------------------------------------
    // Directed stimulus table.
    // ------------------------------------------------------------------------------------
    stim_row_t directed_rows[$];

    function automatic void add_row(input row_op_t op, input string text, input logic [63:0] val,
                                    input bit typed, input bit hits, input logic [7:0] ch,
                                    input logic signed [31:0] idx);
        stim_row_t r;
        r.op    = op;
        r.text  = text;
        r.val   = val;
        r.typed = typed;
        r.hits  = hits;
        r.ch    = ch;
        r.idx   = idx;
        directed_rows.push_back(r);
    endfunction

    // Slot characters for the directed part: space, 'a', 'b', '#', 0xFF, zero, ';', 'z'.
    // Space, zero and ';' never get into a header, so those slots can never match.
    localparam logic [63:0] DIRECTED_CHARS = 64'h7A3B_00FF_2362_6120;

    task automatic post_directed(input stim_row_t r, input logic [7:0] b);
        cmd_result_t t;
        if (r.typed && b == CH_SEMI)
        begin
            if (r.hits)
            begin
                t.is_data = 1'b0;
                t.ch      = r.ch;
                t.idx     = r.idx;
                t.db      = 8'd0;
                t.cnt     = '0;
                t.trunc   = 1'b0;
                t.last    = 1'b1;
                cmd_results_due.push_back(t);
            end
        end
        else
        begin
            foreach (fresh_results[i])
                cmd_results_due.push_back(fresh_results[i]);
        end
    endtask

    initial
    begin
        stim_row_t r;

        rst_n    = 1'b0;
        rx_valid = 1'b0;
        rx_byte  = 8'd0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        reg_count = '0;
        reg_chars = '0;
        clear_command();

        // Straight out of reset the count is zero, so nothing can match.
        add_row(ROW_TEXT, "a1;", 0, 1, 0, 0, 0);
        add_row(ROW_CHARS, "", DIRECTED_CHARS, 0, 0, 0, 0);
        // A count above the slot total is clamped at ';'.
        add_row(ROW_COUNT, "", 64'd15, 0, 0, 0, 0);
        add_row(ROW_TEXT, "a;", 0, 1, 1, "a", 0);
        add_row(ROW_TEXT, "xa99999999999;", 0, 1, 1, "a", 32'sh7FFF_FFFF);
        add_row(ROW_TEXT, "a-99999999999;", 0, 1, 1, "a", 32'sh8000_0000);
        // A sign with no digits after it gives index zero.
        add_row(ROW_TEXT, "a+;", 0, 1, 1, "a", 0);
        add_row(ROW_TEXT, "  a-2147483648 data1;", 0, 0, 0, 0, 0);
        // 'b' comes first in the header but 'a' sits in the earlier slot.
        add_row(ROW_TEXT, "b+0042a7 xyz extra tokens ;", 0, 0, 0, 0, 0);
        add_row(ROW_TEXT, "b7 0123456789abcdefghijklmnopqrstuv;", 0, 0, 0, 0, 0);
        add_row(ROW_TEXT, "#-5 ABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789+-=!;", 0, 0, 0, 0, 0);
        // A zero byte inside the index is dropped without a trace.
        add_row(ROW_TEXT, "z1", 0, 0, 0, 0, 0);
        add_row(ROW_BYTE, "", 64'h00, 0, 0, 0, 0);
        add_row(ROW_TEXT, "2 q;", 0, 0, 0, 0, 0);
        add_row(ROW_BYTE, "", 64'hFF, 0, 0, 0, 0);
        add_row(ROW_TEXT, "12 k;", 0, 0, 0, 0, 0);
        // Empty headers and a header without any configured character.
        add_row(ROW_TEXT, ";", 0, 1, 0, 0, 0);
        add_row(ROW_TEXT, "   ;", 0, 1, 0, 0, 0);
        add_row(ROW_TEXT, "qqq dd;", 0, 1, 0, 0, 0);
        add_row(ROW_TEXT, "a1a2-3 q w;", 0, 0, 0, 0, 0);
        // The count is read at ';', so lowering it mid-command drops the 'b' slot.
        add_row(ROW_TEXT, "b9 mid", 0, 0, 0, 0, 0);
        add_row(ROW_COUNT, "", 64'd2, 0, 0, 0, 0);
        add_row(ROW_TEXT, ";", 0, 1, 0, 0, 0);
        add_row(ROW_COUNT, "", 64'd0, 0, 0, 0, 0);
        add_row(ROW_TEXT, "b1;", 0, 1, 0, 0, 0);

        repeat (2)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[n])
        begin
            r = directed_rows[n];
            case (r.op)
                ROW_TEXT:
                begin
                    for (int i = 0; i < r.text.len(); i++)
                    begin
                        put_byte(r.text[i]);
                        post_directed(r, r.text[i]);
                    end
                end
                ROW_BYTE:
                begin
                    put_byte(r.val[7:0]);
                    post_directed(r, r.val[7:0]);
                end
                ROW_COUNT:
                    cfg_write(ADDR_COUNT, r.val);
                default:
                    cfg_write(ADDR_CHARS, r.val);
            endcase
        end

        // Random phases: sender lightly idle and receiver busy, then the reverse, then no
        // idling at all. Configurations include random characters and the all-ones extreme.
        run_phase(21, 51, 4'd8, {$urandom, $urandom});
        run_phase(51, 21, 4'd1, '1);
        run_phase(0, 0, 4'd5, {$urandom, $urandom});

        // Back-pressure: long data tokens while the receiver holds off, so the block fills
        // up and stalls its input.
        cfg_write(ADDR_COUNT, 64'd8);
        cfg_write(ADDR_CHARS, 64'h4847_4645_4443_4241);
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        pressure_pending = 1'b1;
        repeat (5)
            send_command(1'b1);

        // Every owed result must arrive; the watchdog bounds the wait. Then a quiet stretch
        // catches any stray extra result.
        wait_idle();
        if (errors == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule

// ===== serial_command_tokenizer.f =====
hw/rtl/sct_pkg.sv
hw/rtl/serial_command_tokenizer.sv
sim/testbench.sv
